[hdl/utf8_stream_validator_macros.svh]
// ----------------------------------------------------------------------------
// utf8 stream validator assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UTF8V_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8 validator: same-cycle check failed");

// next-cycle implication
`define UTF8V_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 validator: next-cycle check failed");

`else

`define UTF8V_ASSERT_NOW(label, ante, cons)
`define UTF8V_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/utf8v_pkg.sv]
// ----------------------------------------------------------------------------
// utf8v_pkg
// beat types and error codes shared by the utf8 stream validator
// ----------------------------------------------------------------------------
package utf8v_pkg;

  // error codes reported on the result channel
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_PREMATURE = 3'd1;
  localparam logic [2:0] ERR_OVERLONG  = 3'd2;
  localparam logic [2:0] ERR_BAD_CONT  = 3'd3;
  localparam logic [2:0] ERR_BAD_LEAD  = 3'd4;

  localparam int unsigned OUT_OFFSET_BITS = 16;

  // one string byte or a bare end marker
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_beat_t;

  // one verdict per string
  typedef struct packed {
    logic                       valid_res;
    logic [2:0]                 error_code;
    logic [OUT_OFFSET_BITS-1:0] error_offset;
    logic [7:0]                 bad_lead_byte;
  } out_beat_t;

  // result handed from the checker core to the output stage
  typedef struct packed {
    logic      push;
    out_beat_t beat;
  } core_res_t;

endpackage

[hdl/utf8v_core.sv]
// ----------------------------------------------------------------------------
// utf8v_core
// per-byte utf8 structure check, string state and verdict generation
// ----------------------------------------------------------------------------
`include "utf8_stream_validator_macros.svh"

module utf8v_core import utf8v_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  in_beat_t  beat,
  output core_res_t res
);

  localparam logic [OFFSET_BITS-1:0] CNT_MAX = {OFFSET_BITS{1'b1}};

  logic [1:0]             bytes_left_r, bytes_left_nxt;
  logic [1:0]             char_kind_r, char_kind_nxt;
  logic                   lead_zero_r, lead_zero_nxt;
  logic                   ovl_pend_r, ovl_pend_nxt;
  logic                   bad_pend_r, bad_pend_nxt;
  logic [OFFSET_BITS-1:0] char_start_r, char_start_nxt;
  logic [OFFSET_BITS-1:0] byte_count_r, byte_count_nxt;
  logic                   failed_r, failed_nxt;
  logic [2:0]             saved_code_r, saved_code_nxt;
  logic [OFFSET_BITS-1:0] saved_offset_r, saved_offset_nxt;
  logic [7:0]             saved_byte_r, saved_byte_nxt;

  logic [7:0]             b;
  logic [7:0]             second_mask;
  logic [OFFSET_BITS-1:0] rep_offset;
  logic [OFFSET_BITS+OUT_OFFSET_BITS-1:0] rep_offset_ext;

  assign b = beat.data_byte;
  assign second_mask = (char_kind_r == 2'd2) ? 8'h20 : 8'h30;

  // next string state and verdict
  always_comb begin
    bytes_left_nxt   = bytes_left_r;
    char_kind_nxt    = char_kind_r;
    lead_zero_nxt    = lead_zero_r;
    ovl_pend_nxt     = ovl_pend_r;
    bad_pend_nxt     = bad_pend_r;
    char_start_nxt   = char_start_r;
    byte_count_nxt   = byte_count_r;
    failed_nxt       = failed_r;
    saved_code_nxt   = saved_code_r;
    saved_offset_nxt = saved_offset_r;
    saved_byte_nxt   = saved_byte_r;
    res              = '0;
    rep_offset       = '0;

    if (en && beat.has_byte && !failed_r) begin
      if (bytes_left_r == 2'd0) begin
        // lead byte classification
        if (b[7] == 1'b0) begin
          // single byte, nothing to track
        end else if (b inside {[8'hc0:8'hdf]}) begin
          char_kind_nxt  = 2'd1;
          bytes_left_nxt = 2'd1;
          ovl_pend_nxt   = ((b & 8'h1e) == 8'h00);
          bad_pend_nxt   = 1'b0;
          char_start_nxt = byte_count_r;
        end else if (b inside {[8'he0:8'hef]}) begin
          char_kind_nxt  = 2'd2;
          bytes_left_nxt = 2'd2;
          lead_zero_nxt  = (b[3:0] == 4'h0);
          ovl_pend_nxt   = 1'b0;
          bad_pend_nxt   = 1'b0;
          char_start_nxt = byte_count_r;
        end else if (b inside {[8'hf0:8'hf7]}) begin
          char_kind_nxt  = 2'd3;
          bytes_left_nxt = 2'd3;
          lead_zero_nxt  = (b[2:0] == 3'h0);
          ovl_pend_nxt   = 1'b0;
          bad_pend_nxt   = 1'b0;
          char_start_nxt = byte_count_r;
        end else begin
          failed_nxt       = 1'b1;
          saved_code_nxt   = ERR_BAD_LEAD;
          saved_offset_nxt = byte_count_r;
          saved_byte_nxt   = b;
        end
      end else begin
        // continuation byte: overlong test on the second byte of long forms
        if ((bytes_left_r == char_kind_r) && (char_kind_r >= 2'd2) && lead_zero_r &&
            ((b & second_mask) == 8'h00)) begin
          ovl_pend_nxt = 1'b1;
        end
        if (b[7:6] != 2'b10) begin
          bad_pend_nxt = 1'b1;
        end
        bytes_left_nxt = bytes_left_r - 2'd1;
        // character complete: judge it
        if (bytes_left_nxt == 2'd0) begin
          if (ovl_pend_nxt) begin
            failed_nxt       = 1'b1;
            saved_code_nxt   = ERR_OVERLONG;
            saved_offset_nxt = char_start_r;
            saved_byte_nxt   = 8'h00;
          end else if (bad_pend_nxt) begin
            failed_nxt       = 1'b1;
            saved_code_nxt   = ERR_BAD_CONT;
            saved_offset_nxt = char_start_r;
            saved_byte_nxt   = 8'h00;
          end
          ovl_pend_nxt = 1'b0;
          bad_pend_nxt = 1'b0;
        end
      end
      // saturating byte offset
      if (byte_count_r != CNT_MAX) begin
        byte_count_nxt = byte_count_r + 1'b1;
      end
    end

    // end of string: build verdict and clear
    if (en && beat.last) begin
      res.push = 1'b1;
      if (failed_nxt) begin
        res.beat.error_code    = saved_code_nxt;
        rep_offset             = saved_offset_nxt;
        res.beat.bad_lead_byte = saved_byte_nxt;
      end else if (bytes_left_nxt != 2'd0) begin
        res.beat.error_code    = ERR_PREMATURE;
        rep_offset             = char_start_nxt;
      end else begin
        res.beat.error_code    = ERR_NONE;
      end
      res.beat.valid_res = (res.beat.error_code == ERR_NONE);

      bytes_left_nxt   = '0;
      char_kind_nxt    = '0;
      lead_zero_nxt    = 1'b0;
      ovl_pend_nxt     = 1'b0;
      bad_pend_nxt     = 1'b0;
      char_start_nxt   = '0;
      byte_count_nxt   = '0;
      failed_nxt       = 1'b0;
      saved_code_nxt   = ERR_NONE;
      saved_offset_nxt = '0;
      saved_byte_nxt   = '0;
    end

    // reported offset cut or zero-extended to the port width
    rep_offset_ext        = {{OUT_OFFSET_BITS{1'b0}}, rep_offset};
    res.beat.error_offset = rep_offset_ext[OUT_OFFSET_BITS-1:0];
  end

  // string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r   <= '0;
      char_kind_r    <= '0;
      lead_zero_r    <= 1'b0;
      ovl_pend_r     <= 1'b0;
      bad_pend_r     <= 1'b0;
      char_start_r   <= '0;
      byte_count_r   <= '0;
      failed_r       <= 1'b0;
      saved_code_r   <= ERR_NONE;
      saved_offset_r <= '0;
      saved_byte_r   <= '0;
    end else begin
      bytes_left_r   <= bytes_left_nxt;
      char_kind_r    <= char_kind_nxt;
      lead_zero_r    <= lead_zero_nxt;
      ovl_pend_r     <= ovl_pend_nxt;
      bad_pend_r     <= bad_pend_nxt;
      char_start_r   <= char_start_nxt;
      byte_count_r   <= byte_count_nxt;
      failed_r       <= failed_nxt;
      saved_code_r   <= saved_code_nxt;
      saved_offset_r <= saved_offset_nxt;
      saved_byte_r   <= saved_byte_nxt;
    end
  end

  // a closed string leaves a clean counter behind
  `UTF8V_ASSERT_NEXT(a_clear_after_last, en && beat.last, byte_count_r == '0 && !failed_r)
  // pending continuation count never exceeds the character's length
  `UTF8V_ASSERT_NOW(a_left_within_kind, bytes_left_r != 2'd0, bytes_left_r <= char_kind_r)
  // a verdict only comes with an accepted end-of-string beat
  `UTF8V_ASSERT_NOW(a_push_only_on_last, res.push, en && beat.last)

endmodule

[hdl/utf8v_skid.sv]
// ----------------------------------------------------------------------------
// utf8v_skid
// result register with one skid entry; the core waits only when both are full
// ----------------------------------------------------------------------------
`include "utf8_stream_validator_macros.svh"

module utf8v_skid import utf8v_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  core_res_t res,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic      main_valid_r;
  logic      skid_valid_r;
  out_beat_t main_r;
  out_beat_t skid_r;
  logic      take;

  assign take      = main_valid_r && !out_stall;
  assign out_valid = main_valid_r;
  assign out_beat  = main_r;
  assign full      = skid_valid_r;

  // main and skid entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (take || !main_valid_r) begin
        if (skid_valid_r) begin
          main_valid_r <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          main_valid_r <= res.push;
        end
      end else if (res.push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (take || !main_valid_r) begin
      main_r <= skid_valid_r ? skid_r : res.beat;
    end else if (res.push) begin
      skid_r <= res.beat;
    end
  end

  `UTF8V_ASSERT_NOW(a_skid_implies_main, skid_valid_r, main_valid_r)
  `UTF8V_ASSERT_NOW(a_no_push_when_full, res.push, !skid_valid_r)
  `UTF8V_ASSERT_NEXT(a_stalled_push_skids, main_valid_r && out_stall && res.push, skid_valid_r)

endmodule

[hdl/utf8_stream_validator.sv]
// ----------------------------------------------------------------------------
// utf8_stream_validator
// streaming utf8 structure checker, one verdict per string
// ----------------------------------------------------------------------------
// Usage: feed a string one byte per beat on in_beat (has_byte = 1), marking
// the final beat with last; a beat with has_byte = 0 and last = 1 closes an
// empty string. Each string yields exactly one out_beat: valid_res, or the
// first error with its code, the offset of the faulty character's lead byte
// and, for a disallowed lead, that byte.
// Throughput: one byte per cycle, back to back across strings, while in_stall
// is low; the per-byte check is a single pass over a few state bits.
// Path: a verdict passes the input register, then the result register (held
// in the skid entry while that register is stalled), and shows on out_valid.
// Receiver stall: the result register plus one skid entry absorb a stalled
// result; in_stall rises only when both are full and a beat waits in the
// input register, so a stalled result does not block the next byte.
// Reset: rst_n (synchronous, active low) clears all string state and drops
// out_valid; in_stall is low right after reset.
// ----------------------------------------------------------------------------
module utf8_stream_validator import utf8v_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic      in_valid_r;
  in_beat_t  in_beat_r;
  logic      skid_full;
  logic      core_en;
  core_res_t core_res;

  assign in_stall = in_valid_r && skid_full;
  assign core_en  = in_valid_r && !skid_full;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_beat_r <= in_beat;
    end
  end

  // byte checker and string state
  utf8v_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (core_en),
    .beat (in_beat_r),
    .res  (core_res)
  );

  // result register and skid entry
  utf8v_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (core_res),
    .full     (skid_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

endmodule

[tb/utf8_stream_validator_tb.sv]
// ----------------------------------------------------------------------------
// utf8_stream_validator_tb
// drives strings one byte per beat and scores one verdict per string.
// a short table of hand-picked strings (edge bytes, every error class,
// priority between faults, bare beats) runs first, then random strings that
// are mostly well formed with overlong, bad continuation, bad lead, truncated
// and noise characters mixed in. verdicts come from a behavioral copy of the
// checker, or from values typed into the table where they are obvious.
// ----------------------------------------------------------------------------
module utf8_stream_validator_tb import utf8v_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // directed table row: one input beat plus an optional hand-typed verdict
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last;
    logic        typed;
    logic [2:0]  code;
    logic [15:0] offs;
    logic [7:0]  lead;
  } probe_row_t;

  localparam probe_row_t PROBES [26] = '{
    // empty string right after reset
    '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE,      16'd0, 8'h00},
    // lowest and highest single-byte chars
    '{8'h00, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h7f, 1'b1, 1'b1, 1'b1, ERR_NONE,      16'd0, 8'h00},
    // top byte as lead, the rest of the string ignored
    '{8'hff, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'hc0, 1'b1, 1'b1, 1'b1, ERR_BAD_LEAD,  16'd0, 8'hff},
    // lowest continuation byte where a lead is due
    '{8'h80, 1'b1, 1'b1, 1'b1, ERR_BAD_LEAD,  16'd0, 8'h80},
    // two-byte overlong after one ascii char
    '{8'h41, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'hc1, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'hbf, 1'b1, 1'b1, 1'b1, ERR_OVERLONG,  16'd1, 8'h00},
    // three-byte overlong
    '{8'he0, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h9f, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h80, 1'b1, 1'b1, 1'b1, ERR_OVERLONG,  16'd0, 8'h00},
    // truncated four-byte overlong: premature end wins
    '{8'hf0, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h80, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h80, 1'b1, 1'b1, 1'b1, ERR_PREMATURE, 16'd0, 8'h00},
    // bad continuation in the middle of a three-byte char
    '{8'he2, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h28, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'ha1, 1'b1, 1'b1, 1'b1, ERR_BAD_CONT,  16'd0, 8'h00},
    // overlong and bad continuation in one char: overlong wins
    '{8'he0, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h80, 1'b1, 1'b1, 1'b1, ERR_OVERLONG,  16'd0, 8'h00},
    // f5 lead accepted, bare beat inside the char
    '{8'hf5, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h3c, 1'b0, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h80, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h80, 1'b1, 1'b0, 1'b0, ERR_NONE,      16'd0, 8'h00},
    '{8'h80, 1'b1, 1'b1, 1'b0, ERR_NONE,      16'd0, 8'h00}
  };

  localparam int RANDOM_PER_PHASE = 375;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  // beat side info: use a typed verdict instead of the predicted one
  logic      drv_typed = 1'b0;
  out_beat_t drv_want = '0;

  int gap_pct = 0;
  int stall_pct = 0;
  int miss_count = 0;

  out_beat_t verdict_q[$];
  in_beat_t  text_q[$];
  out_beat_t pred_v;
  out_beat_t seen_v;

  // checker state copy
  logic [1:0]  pend_conts = '0;
  logic [1:0]  seq_len = '0;
  logic        lead_payload_zero = 1'b0;
  logic        overlong_seen = 1'b0;
  logic        badcont_seen = 1'b0;
  logic [15:0] seq_start = '0;
  logic [15:0] str_pos = '0;
  logic        str_failed = 1'b0;
  logic [2:0]  kept_code = ERR_NONE;
  logic [15:0] kept_offset = '0;
  logic [7:0]  kept_lead = '0;

  utf8_stream_validator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always #5 clk = ~clk;

  function automatic void keep_error(logic [2:0] code, logic [15:0] offs, logic [7:0] b);
    str_failed = 1'b1;
    kept_code = code;
    kept_offset = offs;
    kept_lead = (code == ERR_BAD_LEAD) ? b : 8'h00;
  endfunction

  // advance the checker copy by one beat; returns 1 when a verdict is due
  function automatic bit judge_beat(input in_beat_t b, output out_beat_t verdict);
    logic [7:0] d;
    logic [7:0] mask;
    d = b.data_byte;
    verdict = '0;
    if (b.has_byte && !str_failed) begin
      if (pend_conts == 2'd0) begin
        // lead byte classes
        if (!d[7]) begin
        end else if (d[7:5] == 3'b110) begin
          seq_len = 2'd1;
          pend_conts = 2'd1;
          overlong_seen = (d[4:1] == 4'd0);
          badcont_seen = 1'b0;
          seq_start = str_pos;
        end else if (d[7:4] == 4'b1110) begin
          seq_len = 2'd2;
          pend_conts = 2'd2;
          lead_payload_zero = (d[3:0] == 4'd0);
          overlong_seen = 1'b0;
          badcont_seen = 1'b0;
          seq_start = str_pos;
        end else if (d[7:3] == 5'b11110) begin
          seq_len = 2'd3;
          pend_conts = 2'd3;
          lead_payload_zero = (d[2:0] == 3'd0);
          overlong_seen = 1'b0;
          badcont_seen = 1'b0;
          seq_start = str_pos;
        end else begin
          keep_error(ERR_BAD_LEAD, str_pos, d);
        end
      end else begin
        // second byte decides overlong for 3- and 4-byte chars
        if (pend_conts == seq_len && seq_len >= 2'd2) begin
          mask = (seq_len == 2'd2) ? 8'h20 : 8'h30;
          if (lead_payload_zero && (d & mask) == 8'h00) overlong_seen = 1'b1;
        end
        if (d[7:6] != 2'b10) badcont_seen = 1'b1;
        pend_conts = pend_conts - 2'd1;
        // judge the char once all its bytes are in
        if (pend_conts == 2'd0) begin
          if (overlong_seen) keep_error(ERR_OVERLONG, seq_start, 8'h00);
          else if (badcont_seen) keep_error(ERR_BAD_CONT, seq_start, 8'h00);
          overlong_seen = 1'b0;
          badcont_seen = 1'b0;
        end
      end
      if (str_pos != 16'hffff) str_pos = str_pos + 16'd1;
    end
    if (!b.last) return 1'b0;

    // end of string verdict
    if (str_failed) begin
      verdict.error_code = kept_code;
      verdict.error_offset = kept_offset;
      verdict.bad_lead_byte = kept_lead;
    end else if (pend_conts != 2'd0) begin
      verdict.error_code = ERR_PREMATURE;
      verdict.error_offset = seq_start;
    end else begin
      verdict.error_code = ERR_NONE;
    end
    verdict.valid_res = (verdict.error_code == ERR_NONE);

    pend_conts = '0;
    seq_len = '0;
    lead_payload_zero = 1'b0;
    overlong_seen = 1'b0;
    badcont_seen = 1'b0;
    seq_start = '0;
    str_pos = '0;
    str_failed = 1'b0;
    kept_code = ERR_NONE;
    kept_offset = '0;
    kept_lead = '0;
    return 1'b1;
  endfunction

  // scoreboard: results first, then new beats into the predictor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("verdict beat with no verdict pending");
        miss_count++;
      end else begin
        seen_v = verdict_q.pop_front();
        if (out_beat.valid_res !== seen_v.valid_res) begin
          $error("valid_res: expected %0d, got %0d", seen_v.valid_res, out_beat.valid_res);
          miss_count++;
        end
        if (out_beat.error_code !== seen_v.error_code) begin
          $error("error_code: expected %0d, got %0d", seen_v.error_code, out_beat.error_code);
          miss_count++;
        end
        if (out_beat.error_offset !== seen_v.error_offset) begin
          $error("error_offset: expected %0d, got %0d",
                 seen_v.error_offset, out_beat.error_offset);
          miss_count++;
        end
        if (out_beat.bad_lead_byte !== seen_v.bad_lead_byte) begin
          $error("bad_lead_byte: expected %02h, got %02h",
                 seen_v.bad_lead_byte, out_beat.bad_lead_byte);
          miss_count++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      if (judge_beat(in_beat, pred_v)) verdict_q.push_back(drv_typed ? drv_want : pred_v);
    end
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic in_beat_t beat_of(logic [7:0] d, logic has, logic last);
    in_beat_t b;
    b.data_byte = d;
    b.has_byte = has;
    b.last = last;
    return b;
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // append one string byte, sometimes after a bare beat
  function automatic void put_byte(logic [7:0] d);
    if ($urandom_range(0, 11) == 0) text_q.push_back(beat_of(8'($urandom), 1'b0, 1'b0));
    text_q.push_back(beat_of(d, 1'b1, 1'b0));
  endfunction

  // append one random char; returns 1 when the string must end right here
  function automatic bit add_char();
    int sel;
    int conts;
    int idx;
    logic [7:0] seq [4];
    logic [7:0] d;
    sel = $urandom_range(0, 99);
    conts = $urandom_range(1, 3);
    // well-formed char of 2 to 4 bytes
    case (conts)
      1: seq[0] = 8'($urandom_range('hc2, 'hdf));
      2: seq[0] = 8'($urandom_range('he0, 'hef));
      default: seq[0] = 8'($urandom_range('hf0, 'hf7));
    endcase
    for (int k = 1; k < 4; k++) seq[k] = cont_byte();
    if (seq[0] == 8'he0) seq[1] = 8'($urandom_range('ha0, 'hbf));
    if (seq[0] == 8'hf0) seq[1] = 8'($urandom_range('h90, 'hbf));

    if (sel < 35) begin
      put_byte(8'($urandom_range(0, 127)));
      return 1'b0;
    end
    if (sel >= 82 && sel < 88) begin
      // disallowed lead
      d = ($urandom_range(0, 1) == 0) ? 8'($urandom_range('h80, 'hbf))
                                      : 8'($urandom_range('hf8, 'hff));
      put_byte(d);
      return 1'b0;
    end
    if (sel >= 94) begin
      put_byte(8'($urandom));
      return 1'b0;
    end
    if (sel >= 70 && sel < 76) begin
      // overlong forms
      case (conts)
        1: seq[0] = {7'b1100000, 1'($urandom)};
        2: begin
          seq[0] = 8'he0;
          seq[1] = 8'($urandom_range('h80, 'h9f));
        end
        default: begin
          seq[0] = 8'hf0;
          seq[1] = 8'($urandom_range('h80, 'h8f));
        end
      endcase
    end else if (sel >= 76 && sel < 82) begin
      // one continuation without the 10 pattern
      idx = $urandom_range(1, conts);
      d = 8'($urandom);
      if (d[7:6] == 2'b10) d[6] = 1'b1;
      seq[idx] = d;
    end else if (sel >= 88) begin
      // truncated char closes the string
      idx = $urandom_range(1, conts);
      for (int k = 0; k < idx; k++) put_byte(seq[k]);
      return 1'b1;
    end
    for (int k = 0; k <= conts; k++) put_byte(seq[k]);
    return 1'b0;
  endfunction

  function automatic void build_string();
    int nchar;
    bit cut;
    text_q.delete();
    nchar = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    cut = 1'b0;
    for (int i = 0; i < nchar && !cut; i++) cut = add_char();
    // close on the final byte or on a bare end beat
    if (text_q.size() == 0 || $urandom_range(0, 7) == 0)
      text_q.push_back(beat_of(8'($urandom), 1'b0, 1'b1));
    else
      text_q[text_q.size() - 1].last = 1'b1;
  endfunction

  // present one beat at the falling edge and hold it until accepted
  task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    drv_typed <= typed;
    drv_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // main sequence
  initial begin
    probe_row_t row;
    out_beat_t want;
    int sent;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          gap_pct = 37;
          stall_pct = 65;
        end
        1: begin
          gap_pct = 65;
          stall_pct = 37;
        end
        default: begin
          gap_pct = 0;
          stall_pct = 0;
        end
      endcase

      if (ph == 0) begin
        // directed table
        for (int i = 0; i < 26; i++) begin
          row = PROBES[i];
          want.valid_res = (row.code == ERR_NONE);
          want.error_code = row.code;
          want.error_offset = row.offs;
          want.bad_lead_byte = row.lead;
          send_beat(beat_of(row.data_byte, row.has_byte, row.last), row.typed, want);
        end
      end

      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        build_string();
        foreach (text_q[k]) begin
          send_beat(text_q[k], 1'b0, '0);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (miss_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/utf8v_pkg.sv
hdl/utf8v_core.sv
hdl/utf8v_skid.sv
hdl/utf8_stream_validator.sv
tb/utf8_stream_validator_tb.sv
